[rtl/core/csmacd_pkg.sv]
package csmacd_pkg;

   // Request operation codes.
   localparam logic [1:0] OP_TICK     = 2'd0;
   localparam logic [1:0] OP_SEND     = 2'd1;
   localparam logic [1:0] OP_OUTCOME  = 2'd2;
   localparam logic [1:0] OP_JAM_DONE = 2'd3;

   // Command codes.
   localparam logic [1:0] CMD_NONE  = 2'd0;
   localparam logic [1:0] CMD_START = 2'd1;
   localparam logic [1:0] CMD_JAM   = 2'd2;

   // Status codes.
   localparam logic [1:0] STS_NONE    = 2'd0;
   localparam logic [1:0] STS_SENT    = 2'd1;
   localparam logic [1:0] STS_DROPPED = 2'd2;
   localparam logic [1:0] STS_BUSY    = 2'd3;

   // Controller phases.
   localparam logic [2:0] PH_IDLE    = 3'd0;
   localparam logic [2:0] PH_WAIT    = 3'd1;
   localparam logic [2:0] PH_TX      = 3'd2;
   localparam logic [2:0] PH_JAM     = 3'd3;
   localparam logic [2:0] PH_BACKOFF = 3'd4;

   // Register indexes of the configuration port.
   localparam logic [1:0] REG_SLOT  = 2'd0;
   localparam logic [1:0] REG_GAP   = 2'd1;
   localparam logic [1:0] REG_RETRY = 2'd2;

   localparam logic [7:0] SLOT_RESET  = 8'd1;
   localparam logic [7:0] GAP_RESET   = 8'd1;
   localparam logic [4:0] RETRY_RESET = 5'd16;

   // Backoff exponent cap and jam timeout in ticks.
   localparam logic [4:0] BACKOFF_EXP_CAP   = 5'd10;
   localparam logic [6:0] JAM_TIMEOUT_TICKS = 7'd100;
   // Width of the random draw, which also bounds the slot mask.
   localparam logic [4:0] DRAW_BITS         = 5'd10;

   typedef struct packed {
      logic [7:0] slot_ticks;
      logic [7:0] gap_ticks;
      logic [4:0] retry_limit;
   } cfg_type;

   typedef struct packed {
      logic [1:0] op;
      logic       line_busy;
      logic       tx_failed;
      logic [9:0] random_draw;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]  command;
      logic [1:0]  status;
      logic [2:0]  mac_state;
      logic [4:0]  attempt_count;
      logic        collision_seen;
      logic [31:0] collision_total;
      logic [31:0] sent_total;
      logic [31:0] dropped_total;
   } rsp_payload_type;

endpackage

[rtl/core/csmacd_if.sv]
// Request channel: one event for the controller.
interface csmacd_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] op;
   logic       line_busy;
   logic       tx_failed;
   logic [9:0] random_draw;

   modport source (output valid, output op, output line_busy, output tx_failed,
                   output random_draw, input ready);
   modport sink (input valid, input op, input line_busy, input tx_failed,
                 input random_draw, output ready);
endinterface

// Result channel: command, status and counters after one request.
interface csmacd_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  command;
   logic [1:0]  status;
   logic [2:0]  mac_state;
   logic [4:0]  attempt_count;
   logic        collision_seen;
   logic [31:0] collision_total;
   logic [31:0] sent_total;
   logic [31:0] dropped_total;

   modport source (output valid, output command, output status, output mac_state,
                   output attempt_count, output collision_seen, output collision_total,
                   output sent_total, output dropped_total, input ready);
   modport sink (input valid, input command, input status, input mac_state,
                 input attempt_count, input collision_seen, input collision_total,
                 input sent_total, input dropped_total, output ready);
endinterface

[rtl/core/csmacd_csr.sv]
// Configuration registers behind an APB-style port.
module csmacd_csr (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [3:0]           csr_paddr,
   input  logic [31:0]          csr_pwdata,
   output logic [31:0]          csr_prdata,
   output logic                 csr_pready,
   output csmacd_pkg::cfg_type  cfg
);

   csmacd_pkg::cfg_type cfg_ff;
   csmacd_pkg::cfg_type cfg_in;
   logic                wr_en;
   logic [1:0]          reg_index;

   assign csr_pready = 1'b1;
   assign reg_index  = csr_paddr[3:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_index)
            csmacd_pkg::REG_SLOT:  cfg_in.slot_ticks  = csr_pwdata[7:0];
            csmacd_pkg::REG_GAP:   cfg_in.gap_ticks   = csr_pwdata[7:0];
            csmacd_pkg::REG_RETRY: cfg_in.retry_limit = csr_pwdata[4:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         csmacd_pkg::REG_SLOT:  csr_prdata = {24'd0, cfg_ff.slot_ticks};
         csmacd_pkg::REG_GAP:   csr_prdata = {24'd0, cfg_ff.gap_ticks};
         csmacd_pkg::REG_RETRY: csr_prdata = {27'd0, cfg_ff.retry_limit};
         default:               csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.slot_ticks  <= csmacd_pkg::SLOT_RESET;
         cfg_ff.gap_ticks   <= csmacd_pkg::GAP_RESET;
         cfg_ff.retry_limit <= csmacd_pkg::RETRY_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[rtl/core/csmacd_core.sv]
// Controller state and its update for one request.
module csmacd_core (
   input  logic                         clock,
   input  logic                         reset,
   input  csmacd_pkg::cfg_type          cfg,
   input  logic                         fire,
   input  csmacd_pkg::req_payload_type  item,
   output csmacd_pkg::rsp_payload_type  result
);

   logic [2:0]  phase_ff,    phase_in;
   logic        in_gap_ff,   in_gap_in;
   logic [4:0]  attempts_ff, attempts_in;
   logic [17:0] delay_ff,    delay_in;
   logic [6:0]  jam_ff,      jam_in;
   logic        collided_ff, collided_in;
   logic [31:0] coll_cnt_ff, coll_cnt_in;
   logic [31:0] sent_cnt_ff, sent_cnt_in;
   logic [31:0] drop_cnt_ff, drop_cnt_in;

   logic [1:0]  command;
   logic [1:0]  status;
   logic        start;
   logic        backoff_done;
   logic [4:0]  exp_k;
   logic [10:0] mask_wide;
   logic [9:0]  slot_mask;
   logic [17:0] backoff_ticks;

   // Slot choice for a collision: draw masked to 2^min(attempts,cap)-1 slots.
   always_comb begin
      exp_k = (attempts_ff < csmacd_pkg::BACKOFF_EXP_CAP) ?
              attempts_ff : csmacd_pkg::BACKOFF_EXP_CAP;
      mask_wide = (11'd1 << exp_k) - 11'd1;
      slot_mask = (exp_k >= csmacd_pkg::DRAW_BITS) ? 10'h3FF : mask_wide[9:0];
      backoff_ticks = {8'd0, item.random_draw & slot_mask} * {10'd0, cfg.slot_ticks};
   end

   always_comb begin
      phase_in     = phase_ff;
      in_gap_in    = in_gap_ff;
      attempts_in  = attempts_ff;
      delay_in     = delay_ff;
      jam_in       = jam_ff;
      collided_in  = collided_ff;
      coll_cnt_in  = coll_cnt_ff;
      sent_cnt_in  = sent_cnt_ff;
      drop_cnt_in  = drop_cnt_ff;
      command      = csmacd_pkg::CMD_NONE;
      status       = csmacd_pkg::STS_NONE;
      start        = 1'b0;
      backoff_done = 1'b0;

      case (item.op)
         csmacd_pkg::OP_TICK: begin
            if (phase_ff == csmacd_pkg::PH_WAIT) begin
               if (!in_gap_ff) begin
                  if (!item.line_busy) begin
                     in_gap_in = 1'b1;
                     delay_in  = {10'd0, cfg.gap_ticks};
                     start     = (cfg.gap_ticks == 8'd0);
                  end
               end else begin
                  if (delay_ff != 18'd0) begin
                     delay_in = delay_ff - 18'd1;
                  end
                  start = (delay_ff <= 18'd1);
               end
               if (start) begin
                  in_gap_in = 1'b0;
                  phase_in  = csmacd_pkg::PH_TX;
                  command   = csmacd_pkg::CMD_START;
               end
            end else if (phase_ff == csmacd_pkg::PH_JAM) begin
               jam_in = jam_ff + 7'd1;
               if (jam_in >= csmacd_pkg::JAM_TIMEOUT_TICKS) begin
                  // Jam timed out: enter backoff.
                  phase_in     = csmacd_pkg::PH_BACKOFF;
                  jam_in       = 7'd0;
                  backoff_done = (delay_ff == 18'd0);
               end
            end else if (phase_ff == csmacd_pkg::PH_BACKOFF) begin
               if (delay_ff != 18'd0) begin
                  delay_in = delay_ff - 18'd1;
               end
               backoff_done = (delay_ff <= 18'd1);
            end
         end
         csmacd_pkg::OP_SEND: begin
            if (phase_ff != csmacd_pkg::PH_IDLE) begin
               status = csmacd_pkg::STS_BUSY;
            end else begin
               attempts_in = 5'd0;
               collided_in = 1'b0;
               in_gap_in   = 1'b0;
               delay_in    = 18'd0;
               jam_in      = 7'd0;
               if (cfg.retry_limit == 5'd0) begin
                  drop_cnt_in = drop_cnt_ff + 32'd1;
                  status      = csmacd_pkg::STS_DROPPED;
               end else begin
                  phase_in = csmacd_pkg::PH_WAIT;
               end
            end
         end
         csmacd_pkg::OP_OUTCOME: begin
            if (phase_ff == csmacd_pkg::PH_TX) begin
               if (!item.tx_failed) begin
                  sent_cnt_in = sent_cnt_ff + 32'd1;
                  phase_in    = csmacd_pkg::PH_IDLE;
                  status      = csmacd_pkg::STS_SENT;
               end else begin
                  collided_in = 1'b1;
                  coll_cnt_in = coll_cnt_ff + 32'd1;
                  delay_in    = backoff_ticks;
                  if (attempts_ff != 5'd31) begin
                     attempts_in = attempts_ff + 5'd1;
                  end
                  jam_in   = 7'd0;
                  phase_in = csmacd_pkg::PH_JAM;
                  command  = csmacd_pkg::CMD_JAM;
               end
            end
         end
         csmacd_pkg::OP_JAM_DONE: begin
            if (phase_ff == csmacd_pkg::PH_JAM) begin
               phase_in     = csmacd_pkg::PH_BACKOFF;
               jam_in       = 7'd0;
               backoff_done = (delay_ff == 18'd0);
            end
         end
         default: ;
      endcase

      // End of backoff: drop the frame at the retry limit, else sense again.
      if (backoff_done) begin
         if (attempts_ff >= cfg.retry_limit) begin
            drop_cnt_in = drop_cnt_ff + 32'd1;
            phase_in    = csmacd_pkg::PH_IDLE;
            status      = csmacd_pkg::STS_DROPPED;
         end else begin
            phase_in  = csmacd_pkg::PH_WAIT;
            in_gap_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= csmacd_pkg::PH_IDLE;
         in_gap_ff   <= 1'b0;
         attempts_ff <= 5'd0;
         delay_ff    <= 18'd0;
         jam_ff      <= 7'd0;
         collided_ff <= 1'b0;
         coll_cnt_ff <= 32'd0;
         sent_cnt_ff <= 32'd0;
         drop_cnt_ff <= 32'd0;
      end else if (fire) begin
         phase_ff    <= phase_in;
         in_gap_ff   <= in_gap_in;
         attempts_ff <= attempts_in;
         delay_ff    <= delay_in;
         jam_ff      <= jam_in;
         collided_ff <= collided_in;
         coll_cnt_ff <= coll_cnt_in;
         sent_cnt_ff <= sent_cnt_in;
         drop_cnt_ff <= drop_cnt_in;
      end
   end

   always_comb begin
      result.command         = command;
      result.status          = status;
      result.mac_state       = phase_in;
      result.attempt_count   = attempts_in;
      result.collision_seen  = collided_in;
      result.collision_total = coll_cnt_in;
      result.sent_total      = sent_cnt_in;
      result.dropped_total   = drop_cnt_in;
   end

endmodule

[rtl/core/csma_cd_transmit_controller.sv]
// Channel   Direction  Handshake        Contents
// req_ch    in         valid / ready    op, line_busy, tx_failed, random_draw
// rsp_ch    out        valid / ready    command, status, mac_state, counters
// csr_*     in         APB-style write  slot_ticks, gap_ticks, retry_limit
//
// Every request passes an input register and a result register. A result is
// computed from the input register and offered on rsp_ch from the result
// register, and one request is taken every cycle while rsp_ch is not stalled;
// the state update for a request is combinational logic.
// Reset is synchronous and active high; it clears the controller state, the
// counters and the configuration registers to their defaults.
// A stalled result holds in the result register while the input register
// still takes one more request; req_ch.ready drops only when both are full.
module csma_cd_transmit_controller (
   input  logic         clock,
   input  logic         reset,
   csmacd_req_if.sink   req_ch,
   csmacd_rsp_if.source rsp_ch,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [3:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   csmacd_pkg::cfg_type         cfg;
   csmacd_pkg::req_payload_type req_item;
   csmacd_pkg::req_payload_type in_item_ff;
   csmacd_pkg::rsp_payload_type result;
   csmacd_pkg::rsp_payload_type out_item_ff;

   logic in_valid_ff, in_valid_in;
   logic out_valid_ff, out_valid_in;
   logic out_free;
   logic fire;
   logic req_accept;

   csmacd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // The result register is free when empty or being drained this cycle.
   assign out_free     = !out_valid_ff || rsp_ch.ready;
   // A request in the input register is processed when its result can move on.
   assign fire         = in_valid_ff && out_free;
   assign req_ch.ready = !in_valid_ff || out_free;
   assign req_accept   = req_ch.valid && req_ch.ready;

   always_comb begin
      req_item.op          = req_ch.op;
      req_item.line_busy   = req_ch.line_busy;
      req_item.tx_failed   = req_ch.tx_failed;
      req_item.random_draw = req_ch.random_draw;
   end

   csmacd_core u_core (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .fire   (fire),
      .item   (in_item_ff),
      .result (result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (fire) begin
         out_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_item_ff <= req_item;
      end
      if (fire) begin
         out_item_ff <= result;
      end
   end

   assign rsp_ch.valid           = out_valid_ff;
   assign rsp_ch.command         = out_item_ff.command;
   assign rsp_ch.status          = out_item_ff.status;
   assign rsp_ch.mac_state       = out_item_ff.mac_state;
   assign rsp_ch.attempt_count   = out_item_ff.attempt_count;
   assign rsp_ch.collision_seen  = out_item_ff.collision_seen;
   assign rsp_ch.collision_total = out_item_ff.collision_total;
   assign rsp_ch.sent_total      = out_item_ff.sent_total;
   assign rsp_ch.dropped_total   = out_item_ff.dropped_total;

endmodule

[sim/csma_cd_transmit_controller_checker.sv]
`timescale 1ns / 100ps

// Watches both channels and the register port, keeps its own copy of the
// controller state and compares every response with the predicted one.
module csma_cd_transmit_controller_checker import csmacd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   csmacd_req_if       req_ch,
   csmacd_rsp_if       rsp_ch,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic        csr_pready,
   output int unsigned fail_count,
   output int unsigned expected_left
);

   logic [7:0]  slot_len;
   logic [7:0]  gap_len;
   logic [4:0]  retry_cap;

   logic [2:0]  mac_phase;
   logic        gap_running;
   logic [4:0]  frame_collisions;
   logic [17:0] ticks_left;
   logic [6:0]  jam_ticks;
   logic        frame_collided;
   logic [31:0] collisions_seen;
   logic [31:0] frames_sent;
   logic [31:0] frames_dropped;

   rsp_payload_type expected_reports[$];
   int unsigned     mismatches = 0;

   assign fail_count = mismatches;

   // Backoff is over: give up on the frame or go back to carrier sense.
   function automatic logic [1:0] close_backoff();
      if (frame_collisions >= retry_cap) begin
         frames_dropped = frames_dropped + 32'd1;
         mac_phase = PH_IDLE;
         return STS_DROPPED;
      end
      mac_phase = PH_WAIT;
      gap_running = 1'b0;
      return STS_NONE;
   endfunction

   function automatic logic [1:0] close_jam();
      mac_phase = PH_BACKOFF;
      jam_ticks = '0;
      if (ticks_left == '0) return close_backoff();
      return STS_NONE;
   endfunction

   function automatic rsp_payload_type advance_controller(req_payload_type rq);
      rsp_payload_type r;
      logic            start;
      logic [4:0]      exponent;
      logic [9:0]      slot_mask;
      r = '0;
      start = 1'b0;
      case (rq.op)
         OP_TICK: begin
            if (mac_phase == PH_WAIT) begin
               if (!gap_running) begin
                  if (!rq.line_busy) begin
                     gap_running = 1'b1;
                     ticks_left = {10'd0, gap_len};
                     start = (gap_len == 8'd0);
                  end
               end else begin
                  if (ticks_left != '0) ticks_left = ticks_left - 18'd1;
                  start = (ticks_left == '0);
               end
               if (start) begin
                  gap_running = 1'b0;
                  mac_phase = PH_TX;
                  r.command = CMD_START;
               end
            end else if (mac_phase == PH_JAM) begin
               jam_ticks = jam_ticks + 7'd1;
               if (jam_ticks >= JAM_TIMEOUT_TICKS) r.status = close_jam();
            end else if (mac_phase == PH_BACKOFF) begin
               if (ticks_left != '0) ticks_left = ticks_left - 18'd1;
               if (ticks_left == '0) r.status = close_backoff();
            end
         end
         OP_SEND: begin
            if (mac_phase != PH_IDLE) begin
               r.status = STS_BUSY;
            end else begin
               frame_collisions = '0;
               frame_collided = 1'b0;
               gap_running = 1'b0;
               ticks_left = '0;
               jam_ticks = '0;
               if (retry_cap == '0) begin
                  frames_dropped = frames_dropped + 32'd1;
                  r.status = STS_DROPPED;
               end else begin
                  mac_phase = PH_WAIT;
               end
            end
         end
         OP_OUTCOME: begin
            if (mac_phase == PH_TX) begin
               if (!rq.tx_failed) begin
                  frames_sent = frames_sent + 32'd1;
                  mac_phase = PH_IDLE;
                  r.status = STS_SENT;
               end else begin
                  exponent = (frame_collisions < BACKOFF_EXP_CAP) ? frame_collisions
                                                                  : BACKOFF_EXP_CAP;
                  slot_mask = 10'((11'd1 << exponent) - 11'd1);
                  frame_collided = 1'b1;
                  collisions_seen = collisions_seen + 32'd1;
                  ticks_left = 18'(rq.random_draw & slot_mask) * 18'(slot_len);
                  if (frame_collisions < 5'd31) frame_collisions = frame_collisions + 5'd1;
                  jam_ticks = '0;
                  mac_phase = PH_JAM;
                  r.command = CMD_JAM;
               end
            end
         end
         default: begin
            if (mac_phase == PH_JAM) r.status = close_jam();
         end
      endcase
      r.mac_state = mac_phase;
      r.attempt_count = frame_collisions;
      r.collision_seen = frame_collided;
      r.collision_total = collisions_seen;
      r.sent_total = frames_sent;
      r.dropped_total = frames_dropped;
      return r;
   endfunction

   task automatic check_field(input string label, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t %s mismatch: expected %0d actual %0d", $time, label, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      rsp_payload_type want;
      rsp_payload_type got;
      req_payload_type rq;
      if (reset) begin
         slot_len = SLOT_RESET;
         gap_len = GAP_RESET;
         retry_cap = RETRY_RESET;
         mac_phase = PH_IDLE;
         gap_running = 1'b0;
         frame_collisions = '0;
         ticks_left = '0;
         jam_ticks = '0;
         frame_collided = 1'b0;
         collisions_seen = '0;
         frames_sent = '0;
         frames_dropped = '0;
         expected_reports.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[3:2])
               REG_SLOT:  slot_len = csr_pwdata[7:0];
               REG_GAP:   gap_len = csr_pwdata[7:0];
               REG_RETRY: retry_cap = csr_pwdata[4:0];
               default: ;
            endcase
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = {rsp_ch.command, rsp_ch.status, rsp_ch.mac_state, rsp_ch.attempt_count,
                   rsp_ch.collision_seen, rsp_ch.collision_total, rsp_ch.sent_total,
                   rsp_ch.dropped_total};
            if (expected_reports.size() == 0) begin
               $display("%0t stray response: expected none actual %p", $time, got);
               mismatches++;
            end else begin
               want = expected_reports.pop_front();
               check_field("command", 32'(want.command), 32'(got.command));
               check_field("status", 32'(want.status), 32'(got.status));
               check_field("mac_state", 32'(want.mac_state), 32'(got.mac_state));
               check_field("attempt_count", 32'(want.attempt_count), 32'(got.attempt_count));
               check_field("collision_seen", 32'(want.collision_seen),
                           32'(got.collision_seen));
               check_field("collision_total", want.collision_total, got.collision_total);
               check_field("sent_total", want.sent_total, got.sent_total);
               check_field("dropped_total", want.dropped_total, got.dropped_total);
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            rq = {req_ch.op, req_ch.line_busy, req_ch.tx_failed, req_ch.random_draw};
            expected_reports.push_back(advance_controller(rq));
         end
      end
      expected_left <= expected_reports.size();
   end

endmodule

[sim/csma_cd_transmit_controller_tb.sv]
`timescale 1ns / 100ps

// Top of the controller regression. This module only makes stimulus and
// gives the verdict; the checker beside the block predicts every response.
module csma_cd_transmit_controller_tb;
   import csmacd_pkg::*;

   // The run is about a thousand requests, so this guard is far beyond any
   // correct run and only ends a hung one.
   localparam int unsigned CYCLE_LIMIT = 1000000;
   // Each response passes the input register and the result register of the
   // block; this drain after the last one is plenty.
   localparam int unsigned DRAIN_CYCLES = 8;
   // Requests spent on each register setting before moving on.
   localparam int unsigned PHASE_REQUESTS = 40;
   // Backoffs longer than this are cut down so that runs stay short.
   localparam int unsigned BACKOFF_CEILING = 100;
   localparam int unsigned PHASE_COUNT = 8;

   // Register settings per phase: slot length, gap length, retry limit.
   // The extremes are here, along with a zero slot and a zero retry limit.
   localparam int unsigned SLOT_PLAN [0:PHASE_COUNT-1]  = '{3, 1, 255, 0, 2, 5, 1, 128};
   localparam int unsigned GAP_PLAN [0:PHASE_COUNT-1]   = '{2, 0, 255, 3, 1, 1, 0, 17};
   localparam int unsigned RETRY_PLAN [0:PHASE_COUNT-1] = '{16, 2, 1, 31, 0, 12, 16, 5};

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [3:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int unsigned fail_count;
   int unsigned expected_left;
   int unsigned cycle_count = 0;
   int unsigned requests_sent = 0;
   // Request count at which the current register setting is left.
   int unsigned budget = 0;

   // Copies of the register values last written, used to shape frames.
   int unsigned slot_now;
   int unsigned gap_now;
   int unsigned retry_now;

   // Pacing of both channels.
   bit          pauses_on = 1'b1;
   bit          rsp_calm = 1'b0;
   logic        rsp_take = 1'b1;
   int unsigned stall_left = 0;

   csmacd_req_if req_ch();
   csmacd_rsp_if rsp_ch();

   assign rsp_ch.ready = rsp_take;

   csma_cd_transmit_controller dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   csma_cd_transmit_controller_checker outcome_check (
      .clock         (clock),
      .reset         (reset),
      .req_ch        (req_ch),
      .rsp_ch        (rsp_ch),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_pready    (csr_pready),
      .fail_count    (fail_count),
      .expected_left (expected_left)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // The response side stalls in bursts: mostly short holds with an
   // occasional long one. Now and then it switches into a calm stretch in
   // which it takes every response at once, and back again.
   always @(posedge clock) begin
      if (stall_left != 0) begin
         rsp_take <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (!rsp_calm && $urandom_range(0, 99) < 25) begin
         rsp_take <= 1'b0;
         stall_left <= ($urandom_range(0, 11) == 0) ? $urandom_range(8, 40)
                                                    : $urandom_range(0, 2);
      end else begin
         rsp_take <= 1'b1;
      end
      if ($urandom_range(0, 199) == 0) rsp_calm <= ~rsp_calm;
   end

   function automatic logic coin();
      return 1'($urandom_range(0, 1));
   endfunction

   function automatic logic [9:0] any_draw();
      return 10'($urandom);
   endfunction

   // Offers one request and returns at the edge at which it is accepted.
   // The valid line is only lowered when a pause is taken, so back-to-back
   // requests keep it high with a single assignment per edge.
   task automatic issue(input logic [1:0] op, input logic busy, input logic failed,
                        input logic [9:0] draw);
      int unsigned pause;
      pause = 0;
      if (pauses_on && $urandom_range(0, 99) < 30)
         pause = ($urandom_range(0, 15) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
      if (pause != 0) begin
         req_ch.valid <= 1'b0;
         repeat (pause) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.op <= op;
      req_ch.line_busy <= busy;
      req_ch.tx_failed <= failed;
      req_ch.random_draw <= draw;
      do @(posedge clock); while (!req_ch.ready);
      requests_sent++;
   endtask

   // A tick carries random junk in the fields it does not use.
   task automatic tick(input logic busy);
      issue(OP_TICK, busy, coin(), any_draw());
   endtask

   // Stops offering requests and waits until every response is back. The
   // first edge lets the checker record the last accepted request.
   task automatic settle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (expected_left != 0) @(posedge clock);
   endtask

   // Setup and access cycle of a register write. The select is left high so
   // that writes can follow each other; the caller releases the port.
   task automatic write_reg(input logic [1:0] index, input int unsigned value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
   endtask

   task automatic configure(input int unsigned slot, input int unsigned gap,
                            input int unsigned retry);
      settle();
      write_reg(REG_SLOT, slot);
      write_reg(REG_GAP, gap);
      write_reg(REG_RETRY, retry);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      slot_now = slot;
      gap_now = gap;
      retry_now = retry;
   endtask

   // One frame from send request to its end. The sequence follows the
   // controller: carrier sense with some busy samples, the gap, then an
   // outcome. A collision is followed by a jam that ends either on a
   // jam-done report or by running out the timeout, and then exactly as
   // many backoff ticks as the chosen draw asks for. In a storm every
   // attempt collides, so the frame runs into the retry limit and is
   // dropped. Requests that the controller should ignore or refuse are
   // sprinkled in along the way. A frame is cut short once the current
   // register setting has used up its requests.
   task automatic run_frame(input bit storm);
      int unsigned collisions;
      int unsigned exponent;
      int unsigned ticks_due;
      logic [9:0]  draw;
      logic [9:0]  slot_mask;
      bit          finished;
      collisions = 0;
      finished = 1'b0;
      issue(OP_SEND, coin(), coin(), any_draw());
      if ($urandom_range(0, 9) == 0) issue(OP_SEND, coin(), coin(), any_draw());
      // With a zero retry limit the send request itself drops the frame.
      if (retry_now == 0) finished = 1'b1;
      while (!finished && requests_sent < budget) begin
         repeat ($urandom_range(0, 3)) tick(1'b1);
         // The first idle sample opens the gap; busy samples inside it
         // are ignored by the controller.
         tick(1'b0);
         repeat (gap_now) begin
            if ($urandom_range(0, 19) == 0)
               issue(coin() ? OP_OUTCOME : OP_JAM_DONE, coin(), coin(), any_draw());
            tick(coin());
         end
         if ($urandom_range(0, 9) == 0) issue(OP_SEND, coin(), coin(), any_draw());
         if ($urandom_range(0, 9) == 0) tick(coin());
         if (!storm && coin()) begin
            issue(OP_OUTCOME, coin(), 1'b0, any_draw());
            finished = 1'b1;
         end else begin
            // Mostly small draws, sometimes the full range; a draw that
            // would make the backoff very long is cut to its low bits.
            exponent = (collisions < BACKOFF_EXP_CAP) ? collisions : BACKOFF_EXP_CAP;
            slot_mask = 10'((11'd1 << exponent) - 11'd1);
            draw = ($urandom_range(0, 7) == 0) ? any_draw() : 10'($urandom_range(0, 7));
            if ((draw & slot_mask) * slot_now > BACKOFF_CEILING) draw = draw & 10'd3;
            ticks_due = (draw & slot_mask) * slot_now;
            issue(OP_OUTCOME, coin(), 1'b1, draw);
            collisions++;
            if ($urandom_range(0, 4) == 0) begin
               repeat (JAM_TIMEOUT_TICKS) tick(coin());
            end else begin
               repeat ($urandom_range(0, 6)) tick(coin());
               if (coin()) issue(OP_OUTCOME, coin(), coin(), any_draw());
               issue(OP_JAM_DONE, coin(), coin(), any_draw());
            end
            repeat (ticks_due) tick(coin());
            finished = (collisions >= retry_now);
         end
      end
   endtask

   initial begin
      req_ch.valid <= 1'b0;
      req_ch.op <= OP_TICK;
      req_ch.line_busy <= 1'b0;
      req_ch.tx_failed <= 1'b0;
      req_ch.random_draw <= '0;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      slot_now = SLOT_RESET;
      gap_now = GAP_RESET;
      retry_now = RETRY_RESET;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed part at the reset settings: one slot, one gap tick and
      // sixteen retries. Requests that make no sense in the idle state come
      // first and must leave it alone.
      tick(1'b1);
      issue(OP_OUTCOME, 1'b1, 1'b1, 10'h3FF);
      issue(OP_JAM_DONE, 1'b0, 1'b0, 10'h000);
      // A send request starts carrier sense; a second one is refused.
      issue(OP_SEND, 1'b0, 1'b0, 10'h000);
      issue(OP_SEND, 1'b1, 1'b1, 10'h3FF);
      // A busy sample keeps sensing, an idle one opens the gap, and a busy
      // sample inside the gap still counts it down to the start command.
      tick(1'b1);
      tick(1'b0);
      tick(1'b1);
      // Ticks and jam-done reports do nothing while transmitting.
      tick(1'b0);
      issue(OP_JAM_DONE, 1'b1, 1'b0, 10'h155);
      // First collision: the slot mask is empty, so the backoff is zero and
      // the end of the jam goes straight back to carrier sense.
      issue(OP_OUTCOME, 1'b0, 1'b1, 10'h3FF);
      issue(OP_OUTCOME, 1'b0, 1'b0, 10'h2AA);
      issue(OP_JAM_DONE, 1'b0, 1'b0, 10'h000);
      tick(1'b0);
      tick(1'b0);
      // Second collision: a one-slot backoff that a single tick finishes.
      issue(OP_OUTCOME, 1'b1, 1'b1, 10'h3FF);
      tick(1'b0);
      issue(OP_JAM_DONE, 1'b1, 1'b1, 10'h3FF);
      tick(1'b1);
      tick(1'b0);
      tick(1'b0);
      issue(OP_OUTCOME, 1'b1, 1'b0, 10'h000);
      // With a zero retry limit a send request drops the frame at once.
      configure(1, 0, 0);
      issue(OP_SEND, 1'b0, 1'b0, 10'h000);
      // With a zero gap the idle sample itself issues the start command.
      configure(1, 0, 16);
      issue(OP_SEND, 1'b0, 1'b0, 10'h000);
      tick(1'b0);
      issue(OP_OUTCOME, 1'b0, 1'b0, 10'h3FF);

      // Random part: whole frames with random content under each setting,
      // with a few stray requests of any kind between frames.
      for (int p = 0; p < PHASE_COUNT; p++) begin
         configure(SLOT_PLAN[p], GAP_PLAN[p], RETRY_PLAN[p]);
         budget = requests_sent + PHASE_REQUESTS;
         while (requests_sent < budget) begin
            pauses_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 4) == 0) begin
               repeat ($urandom_range(1, 4))
                  issue(2'($urandom_range(0, 3)), coin(), coin(), any_draw());
            end
            run_frame($urandom_range(0, 3) == 0);
         end
      end

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
